// ===== rtl/core/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Shared types, codes and the register address decode for the mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

   typedef enum logic [1:0] {
      CmdWrite     = 2'd0,
      CmdTick      = 2'd1,
      CmdChrLookup = 2'd2,
      CmdPrgLookup = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      PortNone   = 3'd0,
      PortSelect = 3'd1,
      PortData   = 3'd2,
      PortMirror = 3'd3,
      PortLatch  = 3'd4,
      PortReload = 3'd5,
      PortIrqOff = 3'd6,
      PortIrqOn  = 3'd7
   } port_type;

   // Data port targets, by the low four bits of the select register.
   localparam logic [3:0] SelChrPair0  = 4'd0;
   localparam logic [3:0] SelChrPair1  = 4'd1;
   localparam logic [3:0] SelChr4      = 4'd2;
   localparam logic [3:0] SelChr5      = 4'd3;
   localparam logic [3:0] SelChr6      = 4'd4;
   localparam logic [3:0] SelChr7      = 4'd5;
   localparam logic [3:0] SelPrgLow    = 4'd6;
   localparam logic [3:0] SelPrgMid    = 4'd7;
   localparam logic [3:0] SelChrFine1  = 4'd8;
   localparam logic [3:0] SelChrFine3  = 4'd9;
   localparam logic [3:0] SelPrgHigh   = 4'd15;

   localparam logic [7:0] LastPrgReset = 8'hFF;

   typedef struct packed {
      logic        en;
      cmd_type     cmd;
      port_type    port;
      logic [15:0] address;
      logic [7:0]  data_value;
      logic        in_vblank;
      logic        rendering_on;
   } step_type;

   // The port is picked by address bits 15:13 and bit 0.
   function automatic port_type port_decode(input logic [15:0] addr);
      port_type p;
      case ({addr[15:13], addr[0]})
         4'b1000: p = PortSelect;
         4'b1001: p = PortData;
         4'b1010: p = PortMirror;
         4'b1100: p = PortLatch;
         4'b1101: p = PortReload;
         4'b1110: p = PortIrqOff;
         4'b1111: p = PortIrqOn;
         default: p = PortNone;
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/core/cbm_irq.sv =====
// ----------------------------------------------------------------------------
// Scanline interrupt counter
// Holds the counter, latch, enable and reload request, and fires on expiry.
// ----------------------------------------------------------------------------
module cbm_irq
   import cbm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  step_type step,
   output logic     irq_fire
);

   logic [7:0] counter_ff, counter_in;
   logic [7:0] latch_ff, latch_in;
   logic       enabled_ff, enabled_in;
   logic       pending_ff, pending_in;

   always_comb begin
      counter_in = counter_ff;
      latch_in   = latch_ff;
      enabled_in = enabled_ff;
      pending_in = pending_ff;
      irq_fire   = 1'b0;
      if (step.en && step.cmd == CmdWrite) begin
         case (step.port)
            PortLatch:  latch_in   = step.data_value;
            PortReload: pending_in = 1'b1;
            PortIrqOff: enabled_in = 1'b0;
            PortIrqOn:  enabled_in = 1'b1;
            default:    ;
         endcase
         if (pending_in) begin
            counter_in = latch_in;
         end
      end else if (step.en && step.cmd == CmdTick && !step.in_vblank) begin
         pending_in = 1'b0;
         if (step.rendering_on) begin
            if (counter_ff == 8'd0) begin
               counter_in = latch_ff;
               irq_fire   = enabled_ff;
               pending_in = 1'b1;
            end else begin
               counter_in = counter_ff - 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         latch_ff   <= '0;
         enabled_ff <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         counter_ff <= counter_in;
         latch_ff   <= latch_in;
         enabled_ff <= enabled_in;
         pending_ff <= pending_in;
      end
   end

   a_fire_on_tick: assert property (@(posedge clock) disable iff (reset)
      irq_fire |-> (step.en && step.cmd == CmdTick && enabled_ff))
      else $error("Interrupt fired outside an enabled tick.");

   a_fire_reload: assert property (@(posedge clock) disable iff (reset)
      irq_fire |=> (counter_ff == $past(latch_ff) && pending_ff))
      else $error("Counter did not reload from the latch on expiry.");

endmodule

// ===== rtl/core/cbm_banks.sv =====
// ----------------------------------------------------------------------------
// Bank window registers
// Select register, CHR and PRG windows, mirroring, and bank lookups.
// ----------------------------------------------------------------------------
module cbm_banks
   import cbm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  step_type   step,
   input  logic       cfg_we,
   input  logic [7:0] cfg_data,
   output logic [7:0] bank_number,
   output logic       mirror_next
);

   logic [7:0] select_ff, select_in;
   logic       invert_ff, invert_in;
   logic       mirror_ff;
   logic [7:0] chr_ff [8];
   logic [7:0] prg_ff [4];

   logic       is_write;
   logic       data_we;
   logic       swap;
   logic       use_invert;
   logic [7:0] chr_mask;
   logic [7:0] chr_we;
   logic [3:0] prg_we;

   assign is_write = step.en && step.cmd == CmdWrite;
   assign data_we  = is_write && step.port == PortData;
   assign swap     = select_ff[6];

   always_comb begin
      chr_mask   = 8'h00;
      use_invert = 1'b0;
      prg_we     = 4'b0000;
      case (select_ff[3:0])
         SelChrPair0: begin chr_mask = 8'h03; use_invert = 1'b1; end
         SelChrPair1: begin chr_mask = 8'h0C; use_invert = 1'b1; end
         SelChr4:     begin chr_mask = 8'h10; use_invert = 1'b1; end
         SelChr5:     begin chr_mask = 8'h20; use_invert = 1'b1; end
         SelChr6:     begin chr_mask = 8'h40; use_invert = 1'b1; end
         SelChr7:     begin chr_mask = 8'h80; use_invert = 1'b1; end
         SelChrFine1: chr_mask = 8'h02;
         SelChrFine3: chr_mask = 8'h08;
         SelPrgLow:   prg_we = swap ? 4'b0010 : 4'b0001;
         SelPrgMid:   prg_we = swap ? 4'b0100 : 4'b0010;
         SelPrgHigh:  prg_we = swap ? 4'b0001 : 4'b0100;
         default:     ;
      endcase
      // Inverting swaps the lower and upper halves of the CHR windows.
      if (use_invert && invert_ff) begin
         chr_we = {chr_mask[3:0], chr_mask[7:4]};
      end else begin
         chr_we = chr_mask;
      end
   end

   always_comb begin
      select_in = select_ff;
      invert_in = invert_ff;
      if (is_write && step.port == PortSelect) begin
         select_in = step.data_value;
         invert_in = step.data_value[7];
      end
   end

   assign mirror_next = (is_write && step.port == PortMirror) ?
                        step.data_value[0] : mirror_ff;

   always_comb begin
      case (step.cmd)
         CmdChrLookup: bank_number = chr_ff[step.address[12:10]];
         CmdPrgLookup: bank_number = prg_ff[step.address[14:13]];
         default:      bank_number = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff <= '0;
         invert_ff <= 1'b0;
         mirror_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            chr_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) begin
            prg_ff[i] <= LastPrgReset;
         end
      end else begin
         select_ff <= select_in;
         invert_ff <= invert_in;
         mirror_ff <= mirror_next;
         if (data_we) begin
            for (int i = 0; i < 8; i++) begin
               if (chr_we[i]) begin
                  chr_ff[i] <= step.data_value;
               end
            end
         end
         if (cfg_we) begin
            for (int i = 0; i < 4; i++) begin
               prg_ff[i] <= cfg_data;
            end
         end else if (data_we) begin
            for (int i = 0; i < 4; i++) begin
               if (prg_we[i]) begin
                  prg_ff[i] <= step.data_value;
               end
            end
         end
      end
   end

   a_cfg_load: assert property (@(posedge clock) disable iff (reset)
      cfg_we |=> (prg_ff[0] == $past(cfg_data) && prg_ff[3] == $past(cfg_data)))
      else $error("Configuration write did not load the PRG windows.");

   a_top_window: assert property (@(posedge clock) disable iff (reset)
      !cfg_we |=> prg_ff[3] == $past(prg_ff[3]))
      else $error("Top PRG window changed without a configuration write.");

endmodule

// ===== rtl/core/cartridge_bank_mapper_scanline_irq_unit.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank mapper with scanline interrupt
//
//   Channel  Direction  Handshake            Beat contents
//   req      in         req_valid/req_ready  command, address, data, vblank, rendering
//   rsp      out        rsp_valid/rsp_ready  irq_fire, bank_number, mirror_horizontal
//   csr      in         csr_valid/csr_ready  last_prg_bank
//
// A request beat is registered, executed against the mapper state once the
// response register is free, and its response is registered. While rsp_ready
// holds, one beat per cycle is sustained; the decode and counter update logic
// sits between the request and response registers.
// Reset is synchronous; it empties both registers and restores all state.
// A stalled response holds the request register, which then holds req_ready low.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_scanline_irq_unit
   import cbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data_value,
   input  logic        req_in_vblank,
   input  logic        req_rendering_on,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_irq_fire,
   output logic [7:0]  rsp_bank_number,
   output logic        rsp_mirror_horizontal,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_last_prg_bank
);

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  cmd_ff;
   logic [15:0] address_ff;
   logic [7:0]  data_ff;
   logic        vblank_ff;
   logic        render_ff;

   logic        out_valid_ff, out_valid_in;
   logic        fire_ff;
   logic [7:0]  bank_ff;
   logic        mirror_ff;

   logic        out_free;
   logic        advance;
   logic        req_take;
   step_type    step;
   logic        fire;
   logic [7:0]  bank;
   logic        mirror;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_comb begin
      step.en           = advance;
      step.cmd          = cmd_type'(cmd_ff);
      step.port         = port_decode(address_ff);
      step.address      = address_ff;
      step.data_value   = data_ff;
      step.in_vblank    = vblank_ff;
      step.rendering_on = render_ff;
   end

   cbm_irq u_irq (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .irq_fire (fire)
   );

   cbm_banks u_banks (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .cfg_we      (csr_valid && csr_ready),
      .cfg_data    (csr_last_prg_bank),
      .bank_number (bank),
      .mirror_next (mirror)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff     <= req_command;
         address_ff <= req_address;
         data_ff    <= req_data_value;
         vblank_ff  <= req_in_vblank;
         render_ff  <= req_rendering_on;
      end
      if (advance) begin
         fire_ff   <= fire;
         bank_ff   <= bank;
         mirror_ff <= mirror;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_irq_fire          = fire_ff;
   assign rsp_bank_number       = bank_ff;
   assign rsp_mirror_horizontal = mirror_ff;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("Request stalled without a full pipeline.");

endmodule
